@@ rtl/core/ssaa_pkg.sv @@
// Shared constants and handshake types for the spot sample accumulate average block.
package ssaa_pkg;

   localparam int unsigned MAX_WIDTH_DEF  = 256;
   localparam int unsigned MAX_HEIGHT_DEF = 256;

   localparam int unsigned DIM_W     = 9;
   localparam int unsigned POS_W     = 16;
   localparam int unsigned SIG_W     = 24;
   localparam int unsigned GAIN_W    = 16;
   localparam int unsigned GAIN_FRAC = 14;
   localparam int unsigned CNT_W     = 16;
   localparam int unsigned SUM_W     = 40;
   localparam int unsigned QUOT_W    = 24;
   localparam int unsigned COORD_W   = 12;
   localparam int unsigned ENTRY_W   = SUM_W + CNT_W;

   localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

   localparam logic FUNC_ACCUM = 1'b0;
   localparam logic FUNC_READ  = 1'b1;

   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   typedef struct packed {
      logic              start;
      logic [SUM_W-1:0]  dividend;
      logic [CNT_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic              sat;
      logic [QUOT_W-1:0] quot;
   } div_rsp_type;

endpackage

@@ rtl/core/spot_sample_accumulate_average_top.sv @@
// Top level: sequencer, position check and result register of the spot accumulate block.
// Accumulate and read both use the 24-step shared divider; a clipped quotient skips the
//   divide, and an off-image word or an unhit read never starts it. One word in flight;
//   a stalled result holds the next word in its finish state. Reset: synchronous, then
//   the pixel store is swept clear one entry a cycle over all MAX_WIDTH*MAX_HEIGHT (65536)
//   entries, req_stall high, csr live.
module spot_sample_accumulate_average_top #(
   parameter int unsigned MAX_WIDTH  = ssaa_pkg::MAX_WIDTH_DEF,
   parameter int unsigned MAX_HEIGHT = ssaa_pkg::MAX_HEIGHT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // configuration
   input  logic                          csr_wr_en,
   input  logic                          csr_index,
   input  logic [ssaa_pkg::DIM_W-1:0]    csr_wr_data,
   // request words
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_func,
   input  logic signed [ssaa_pkg::POS_W-1:0] req_sample_x,
   input  logic signed [ssaa_pkg::POS_W-1:0] req_sample_y,
   input  logic [ssaa_pkg::SIG_W-1:0]    req_spot_signal,
   input  logic [ssaa_pkg::GAIN_W-1:0]   req_spot_gain,
   // result words
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_func_echo,
   output logic [ssaa_pkg::QUOT_W-1:0]   rsp_pixel_value,
   output logic                          rsp_hit,
   output logic [ssaa_pkg::CNT_W-1:0]    rsp_hit_count,
   output logic                          rsp_saturated
);

   localparam int unsigned X_W     = $clog2(MAX_WIDTH);
   localparam int unsigned Y_W     = $clog2(MAX_HEIGHT);
   localparam int unsigned DEPTH   = MAX_WIDTH * MAX_HEIGHT;
   localparam int unsigned ADDR_W  = $clog2(DEPTH);
   localparam int unsigned COORD_W = ssaa_pkg::COORD_W;
   localparam int unsigned POS_W   = ssaa_pkg::POS_W;
   localparam int unsigned SUM_W   = ssaa_pkg::SUM_W;
   localparam int unsigned CNT_W   = ssaa_pkg::CNT_W;
   localparam int unsigned SIG_W   = ssaa_pkg::SIG_W;
   localparam int unsigned GAIN_W  = ssaa_pkg::GAIN_W;
   localparam int unsigned QUOT_W  = ssaa_pkg::QUOT_W;
   localparam int unsigned PAD_W   = SUM_W - SIG_W - ssaa_pkg::GAIN_FRAC;

   // sequencer codes
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_ADDR   = 3'd1;
   localparam logic [2:0] ST_READ   = 3'd2;
   localparam logic [2:0] ST_LOAD   = 3'd3;
   localparam logic [2:0] ST_DIV    = 3'd4;
   localparam logic [2:0] ST_UPDATE = 3'd5;
   localparam logic [2:0] ST_FINISH = 3'd6;

   // Round Q12.4 to pixel, halves away from zero. Top bit: not a negative pixel.
   function automatic logic [COORD_W:0] round_pos(input logic [POS_W-1:0] v);
      logic [POS_W:0]   mag;
      logic [POS_W:0]   rnd;
      logic [COORD_W-1:0] pix;
      mag = v[POS_W-1] ? ({1'b1, {POS_W{1'b0}}} - {1'b0, v}) : {1'b0, v};
      rnd = (mag + (POS_W+1)'(8)) >> 4;
      pix = rnd[COORD_W-1:0];
      return {!(v[POS_W-1] && pix != '0), pix};
   endfunction

   logic [2:0]                  state_ff, state_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [ssaa_pkg::DIM_W-1:0]  width_ff, height_ff;

   // item work registers
   logic                        func_ff;
   logic [SIG_W-1:0]            sig_ff;
   logic [GAIN_W-1:0]           gain_ff;
   logic [X_W-1:0]              px_ff;
   logic [Y_W-1:0]              py_ff;
   logic                        inside_ff;
   logic [ADDR_W-1:0]           addr_ff;
   logic [QUOT_W-1:0]           val_ff;
   logic                        hit_ff;
   logic [CNT_W-1:0]            cnt_ff;
   logic                        sat_ff;

   // result register
   logic                        out_func_ff;
   logic [QUOT_W-1:0]           out_value_ff;
   logic                        out_hit_ff;
   logic [CNT_W-1:0]            out_cnt_ff;
   logic                        out_sat_ff;

   logic [COORD_W:0]            xr, yr;
   logic                        inside_x, inside_y;
   logic                        accept;
   logic                        finish;
   logic [ADDR_W-1:0]           addr_in;

   logic                        clearing;
   logic [ssaa_pkg::ENTRY_W-1:0] rd_data;
   logic [SUM_W-1:0]            rd_sum;
   logic [CNT_W-1:0]            rd_cnt;
   logic                        store_wr_en;
   logic [ssaa_pkg::ENTRY_W-1:0] store_wr_data;

   logic [SUM_W:0]              sum_add;
   logic [SUM_W-1:0]            new_sum;
   logic                        cnt_max;
   logic [CNT_W-1:0]            new_cnt;

   ssaa_pkg::div_req_type       div_req;
   ssaa_pkg::div_rsp_type       div_rsp;

   // ---------------------------------------------------------------- position check
   assign xr = round_pos(req_sample_x);
   assign yr = round_pos(req_sample_y);
   // clipped dimension = min(register, MAX): compare against both
   assign inside_x = xr[COORD_W] && (xr[COORD_W-1:0] < COORD_W'(width_ff))
                     && (xr[COORD_W-1:0] < COORD_W'(MAX_WIDTH));
   assign inside_y = yr[COORD_W] && (yr[COORD_W-1:0] < COORD_W'(height_ff))
                     && (yr[COORD_W-1:0] < COORD_W'(MAX_HEIGHT));

   assign req_stall = (state_ff != ST_IDLE) || clearing;
   assign accept    = req_valid && !req_stall;
   // result register is free when empty or being drained this cycle
   assign finish    = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   // pixel (x, y) sits at y * MAX_WIDTH + x
   assign addr_in = ADDR_W'(ADDR_W'(py_ff) * ADDR_W'(MAX_WIDTH) + ADDR_W'(px_ff));

   // ---------------------------------------------------------------- store data paths
   assign rd_sum = rd_data[ssaa_pkg::ENTRY_W-1 -: SUM_W];
   assign rd_cnt = rd_data[CNT_W-1:0];

   // divider operands: signal/gain for accumulate, sum/count for read
   always_comb begin
      div_req.start    = (state_ff == ST_LOAD)
                         && !(func_ff == ssaa_pkg::FUNC_READ && rd_cnt == '0);
      div_req.dividend = rd_sum;
      div_req.divisor  = rd_cnt;
      if (func_ff == ssaa_pkg::FUNC_ACCUM) begin
         div_req.dividend = {{PAD_W{1'b0}}, sig_ff, {ssaa_pkg::GAIN_FRAC{1'b0}}};
         div_req.divisor  = (gain_ff == '0) ? CNT_W'(1) : gain_ff;
      end
   end

   // sum clips at all ones on carry out; count holds at all ones
   assign sum_add       = {1'b0, rd_sum} + (SUM_W+1)'(val_ff);
   assign new_sum       = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
   assign cnt_max       = &rd_cnt;
   assign new_cnt       = cnt_max ? rd_cnt : rd_cnt + CNT_W'(1);
   assign store_wr_en   = (state_ff == ST_UPDATE);
   assign store_wr_data = {new_sum, new_cnt};

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_ADDR;
         ST_ADDR:   state_in = inside_ff ? ST_READ : ST_FINISH;
         ST_READ:   state_in = ST_LOAD;
         ST_LOAD:   state_in = div_req.start ? ST_DIV : ST_FINISH;
         ST_DIV: begin
            if (div_rsp.done) begin
               state_in = (func_ff == ssaa_pkg::FUNC_ACCUM) ? ST_UPDATE : ST_FINISH;
            end
         end
         ST_UPDATE: state_in = ST_FINISH;
         ST_FINISH: if (finish) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         width_ff     <= ssaa_pkg::DIM_RESET;
         height_ff    <= ssaa_pkg::DIM_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               ssaa_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_wr_data;
               ssaa_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_wr_data;
               default: ;
            endcase
         end
      end
   end

   // item payload; result fields start at zero and fill in as the item advances
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff   <= req_func;
         sig_ff    <= req_spot_signal;
         gain_ff   <= req_spot_gain;
         px_ff     <= xr[X_W-1:0];
         py_ff     <= yr[Y_W-1:0];
         inside_ff <= inside_x && inside_y;
         val_ff    <= '0;
         hit_ff    <= 1'b0;
         cnt_ff    <= '0;
         sat_ff    <= 1'b0;
      end
      if (state_ff == ST_ADDR) begin
         addr_ff <= addr_in;
      end
      if (state_ff == ST_DIV && div_rsp.done) begin
         val_ff <= div_rsp.quot;
         sat_ff <= div_rsp.sat;
         hit_ff <= 1'b1;
         cnt_ff <= rd_cnt;
      end
      if (state_ff == ST_UPDATE) begin
         cnt_ff <= new_cnt;
         sat_ff <= sat_ff | sum_add[SUM_W] | cnt_max;
      end
      if (finish) begin
         out_func_ff  <= func_ff;
         out_value_ff <= val_ff;
         out_hit_ff   <= hit_ff;
         out_cnt_ff   <= cnt_ff;
         out_sat_ff   <= sat_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_func_echo   = out_func_ff;
   assign rsp_pixel_value = out_value_ff;
   assign rsp_hit         = out_hit_ff;
   assign rsp_hit_count   = out_cnt_ff;
   assign rsp_saturated   = out_sat_ff;

   // ---------------------------------------------------------------- units
   ssaa_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   ssaa_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (state_ff == ST_READ),
      .rd_addr  (addr_ff),
      .rd_data  (rd_data),
      .wr_en    (store_wr_en),
      .wr_addr  (addr_ff),
      .wr_data  (store_wr_data),
      .clearing (clearing)
   );

`ifndef SYNTHESIS
   a_busy_not_clearing: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !clearing)
      else $error("item in flight during store clear");

   a_accept_to_addr: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_ADDR))
      else $error("accepted word did not start the sequence");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide state");

   a_write_on_hit: assert property (@(posedge clock) disable iff (reset)
      store_wr_en |-> (func_ff == ssaa_pkg::FUNC_ACCUM && hit_ff && inside_ff))
      else $error("store written for a read or a miss");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_pixel_value == '0 && rsp_hit_count == '0
                                   && !rsp_saturated))
      else $error("miss result carries nonzero fields");
`endif

endmodule

@@ rtl/core/ssaa_div.sv @@
// Shared restoring divider, one quotient bit per cycle, clipped at 24 bits.
module ssaa_div (
   input  logic                 clock,
   input  logic                 reset,
   input  ssaa_pkg::div_req_type div_req,
   output ssaa_pkg::div_rsp_type div_rsp
);

   localparam int unsigned QW    = ssaa_pkg::QUOT_W;
   localparam int unsigned RW    = ssaa_pkg::CNT_W;
   localparam int unsigned SW    = ssaa_pkg::SUM_W;
   localparam int unsigned STEP_W = $clog2(QW + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] steps_ff;
   logic [RW-1:0]     rem_ff;
   logic [QW-1:0]     quo_ff;
   logic [RW-1:0]     divisor_ff;
   logic              sat_ff;

   logic [RW:0]       trial;
   logic [RW:0]       diff;
   logic              fits;
   logic              ovf;

   // quotient >= 2^24 exactly when the top bits of the dividend reach the divisor
   assign ovf   = div_req.dividend[SW-1 -: RW] >= div_req.divisor;
   assign trial = {rem_ff, quo_ff[QW-1]};
   assign fits  = trial >= {1'b0, divisor_ff};
   assign diff  = trial - {1'b0, divisor_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         busy_in = !ovf;
         done_in = ovf;
      end else if (busy_ff && steps_ff == STEP_W'(1)) begin
         busy_in = 1'b0;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         divisor_ff <= div_req.divisor;
         rem_ff     <= div_req.dividend[SW-1 -: RW];
         quo_ff     <= ovf ? {QW{1'b1}} : div_req.dividend[QW-1:0];
         sat_ff     <= ovf;
         steps_ff   <= STEP_W'(QW);
      end else if (busy_ff) begin
         rem_ff   <= fits ? diff[RW-1:0] : trial[RW-1:0];
         quo_ff   <= {quo_ff[QW-2:0], fits};
         steps_ff <= steps_ff - STEP_W'(1);
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.sat  = sat_ff;
   assign div_rsp.quot = quo_ff;

endmodule

@@ rtl/core/ssaa_store.sv @@
// Pixel store: sum and hit count per pixel, single port pair, cleared by a sweep after reset.
module ssaa_store #(
   parameter int unsigned DEPTH  = ssaa_pkg::MAX_WIDTH_DEF * ssaa_pkg::MAX_HEIGHT_DEF,
   parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [ADDR_W-1:0]            rd_addr,
   output logic [ssaa_pkg::ENTRY_W-1:0] rd_data,
   input  logic                         wr_en,
   input  logic [ADDR_W-1:0]            wr_addr,
   input  logic [ssaa_pkg::ENTRY_W-1:0] wr_data,
   output logic                         clearing
);

   logic [ssaa_pkg::ENTRY_W-1:0] mem [DEPTH];
   logic [ssaa_pkg::ENTRY_W-1:0] rd_data_ff;
   logic                         clr_ff;
   logic [ADDR_W-1:0]            clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_ff) begin
         clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clr_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clr_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clr_ff;

endmodule

@@ verif/spot_sample_accumulate_average_checker.sv @@
// Checker for the spot accumulate block: predicts each result word and compares it.
`timescale 1ns / 100ps

module spot_sample_accumulate_average_checker #(
   parameter int unsigned MAX_WIDTH  = ssaa_pkg::MAX_WIDTH_DEF,
   parameter int unsigned MAX_HEIGHT = ssaa_pkg::MAX_HEIGHT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic                          csr_index,
   input  logic [ssaa_pkg::DIM_W-1:0]    csr_wr_data,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic                          req_func,
   input  logic [ssaa_pkg::POS_W-1:0]    req_sample_x,
   input  logic [ssaa_pkg::POS_W-1:0]    req_sample_y,
   input  logic [ssaa_pkg::SIG_W-1:0]    req_spot_signal,
   input  logic [ssaa_pkg::GAIN_W-1:0]   req_spot_gain,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic                          rsp_func_echo,
   input  logic [ssaa_pkg::QUOT_W-1:0]   rsp_pixel_value,
   input  logic                          rsp_hit,
   input  logic [ssaa_pkg::CNT_W-1:0]    rsp_hit_count,
   input  logic                          rsp_saturated,
   output int                            mismatches,
   output int                            pending_words
);

   localparam int unsigned DIM_W       = ssaa_pkg::DIM_W;
   localparam int unsigned POS_W       = ssaa_pkg::POS_W;
   localparam int unsigned COORD_W     = ssaa_pkg::COORD_W;
   localparam int unsigned SIG_W       = ssaa_pkg::SIG_W;
   localparam int unsigned GAIN_W      = ssaa_pkg::GAIN_W;
   localparam int unsigned GAIN_FRAC   = ssaa_pkg::GAIN_FRAC;
   localparam int unsigned QUOT_W      = ssaa_pkg::QUOT_W;
   localparam int unsigned CNT_W       = ssaa_pkg::CNT_W;
   localparam int unsigned SUM_W       = ssaa_pkg::SUM_W;
   localparam int unsigned PIXELS      = MAX_WIDTH * MAX_HEIGHT;
   localparam int unsigned POS_FRAC    = POS_W - COORD_W;
   localparam logic [63:0] SUM_LIMIT   = (64'd1 << SUM_W) - 64'd1;
   localparam logic [63:0] VALUE_LIMIT = (64'd1 << QUOT_W) - 64'd1;
   localparam logic [63:0] COUNT_LIMIT = (64'd1 << CNT_W) - 64'd1;

   typedef struct packed {
      logic              func;
      logic [QUOT_W-1:0] value;
      logic              hit;
      logic [CNT_W-1:0]  count;
      logic              sat;
   } pixel_word_type;

   logic [SUM_W-1:0] sum_image   [PIXELS];
   logic [CNT_W-1:0] count_image [PIXELS];
   logic [DIM_W-1:0] width_reg;
   logic [DIM_W-1:0] height_reg;
   pixel_word_type   awaited_words [$];

   // Q12.4 to pixel, halves away from zero; negative pixels are off-image
   function automatic bit round_to_pixel(input logic [POS_W-1:0] raw,
                                         output int unsigned pix);
      int unsigned mag;
      int unsigned p;
      mag = raw[POS_W-1] ? ((32'd1 << POS_W) - raw) : raw;
      p   = (mag + (32'd1 << (POS_FRAC - 1))) >> POS_FRAC;
      pix = p;
      return !(raw[POS_W-1] && p != 0);
   endfunction

   function automatic pixel_word_type predict_pixel_word(input logic              f,
                                                         input logic [POS_W-1:0]  xs,
                                                         input logic [POS_W-1:0]  ys,
                                                         input logic [SIG_W-1:0]  sig,
                                                         input logic [GAIN_W-1:0] gain);
      pixel_word_type w;
      int unsigned px, py, w_use, h_use, addr;
      bit          on_image;
      logic [63:0] sum, cnt, q, div;
      w        = '0;
      w.func   = f;
      px       = 0;
      py       = 0;
      w_use    = (width_reg < MAX_WIDTH) ? width_reg : MAX_WIDTH;
      h_use    = (height_reg < MAX_HEIGHT) ? height_reg : MAX_HEIGHT;
      on_image = round_to_pixel(xs, px);
      if (on_image) on_image = round_to_pixel(ys, py);
      if (on_image && (px >= w_use || py >= h_use)) on_image = 1'b0;
      if (on_image) begin
         addr = py * MAX_WIDTH + px;
         sum  = 64'(sum_image[addr]);
         cnt  = 64'(count_image[addr]);
         if (f == ssaa_pkg::FUNC_ACCUM) begin
            div = (gain == '0) ? 64'd1 : 64'(gain);
            q   = (64'(sig) << GAIN_FRAC) / div;
            if (q > VALUE_LIMIT) begin
               q     = VALUE_LIMIT;
               w.sat = 1'b1;
            end
            if (sum > SUM_LIMIT - q) begin
               sum   = SUM_LIMIT;
               w.sat = 1'b1;
            end else begin
               sum = sum + q;
            end
            if (cnt >= COUNT_LIMIT) w.sat = 1'b1;
            else cnt = cnt + 64'd1;
            sum_image[addr]   = sum[SUM_W-1:0];
            count_image[addr] = cnt[CNT_W-1:0];
            w.value = q[QUOT_W-1:0];
            w.hit   = 1'b1;
         end else if (cnt != 0) begin
            q = sum / cnt;
            if (q > VALUE_LIMIT) begin
               q     = VALUE_LIMIT;
               w.sat = 1'b1;
            end
            w.value = q[QUOT_W-1:0];
            w.hit   = 1'b1;
         end
         w.count = cnt[CNT_W-1:0];
      end
      return w;
   endfunction

   task automatic check_field(input string tag, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s expected %0h got %0h", $time, tag, want, got);
      end
   endtask

   always @(posedge clock) begin
      pixel_word_type want;
      if (reset) begin
         for (int i = 0; i < PIXELS; i++) begin
            sum_image[i]   = '0;
            count_image[i] = '0;
         end
         width_reg  = ssaa_pkg::DIM_RESET;
         height_reg = ssaa_pkg::DIM_RESET;
         awaited_words.delete();
         mismatches = 0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == ssaa_pkg::CSR_IMAGE_WIDTH) width_reg = csr_wr_data;
            else height_reg = csr_wr_data;
         end
         if (req_valid && !req_stall) begin
            want = predict_pixel_word(req_func, req_sample_x, req_sample_y,
                                      req_spot_signal, req_spot_gain);
            awaited_words.insert(awaited_words.size(), want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_words.size() == 0) begin
               mismatches++;
               $display("%0t: result word with none expected, expected nothing got %0h",
                        $time, rsp_pixel_value);
            end else begin
               want = awaited_words.pop_front();
               check_field("func_echo", 32'(want.func), 32'(rsp_func_echo));
               check_field("pixel_value", 32'(want.value), 32'(rsp_pixel_value));
               check_field("hit", 32'(want.hit), 32'(rsp_hit));
               check_field("hit_count", 32'(want.count), 32'(rsp_hit_count));
               check_field("saturated", 32'(want.sat), 32'(rsp_saturated));
            end
         end
      end
      pending_words <= awaited_words.size();
   end

endmodule

@@ verif/spot_sample_accumulate_average_top_tb.sv @@
// Testbench top: drives config and request words into the spot accumulate block, gives verdict.
`timescale 1ns / 100ps

module spot_sample_accumulate_average_top_tb;

   localparam int unsigned DIM_W        = ssaa_pkg::DIM_W;
   localparam int unsigned POS_W        = ssaa_pkg::POS_W;
   localparam int unsigned COORD_W      = ssaa_pkg::COORD_W;
   localparam int unsigned SIG_W        = ssaa_pkg::SIG_W;
   localparam int unsigned GAIN_W       = ssaa_pkg::GAIN_W;
   localparam int unsigned QUOT_W       = ssaa_pkg::QUOT_W;
   localparam int unsigned CNT_W        = ssaa_pkg::CNT_W;
   localparam int unsigned MAX_W        = ssaa_pkg::MAX_WIDTH_DEF;
   localparam int unsigned MAX_H        = ssaa_pkg::MAX_HEIGHT_DEF;
   // one pixel step in the Q12.4 positions: one shifted by the frac bits
   localparam int          PIX_STEP     = 1 << (POS_W - COORD_W);
   localparam int          PHASES       = 9;
   localparam int          PHASE_WORDS  = 54;
   // covers the post-reset store sweep with room to spare
   localparam int          IDLE_LIMIT   = 3 * MAX_W * MAX_H + 2000;
   // margin left after the last result before the verdict
   localparam int          TAIL_CYCLES  = 40;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_wr_en = 1'b0;
   logic                     csr_index = ssaa_pkg::CSR_IMAGE_WIDTH;
   logic [DIM_W-1:0]         csr_wr_data = '0;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_func = ssaa_pkg::FUNC_ACCUM;
   logic signed [POS_W-1:0]  req_sample_x = '0;
   logic signed [POS_W-1:0]  req_sample_y = '0;
   logic [SIG_W-1:0]         req_spot_signal = '0;
   logic [GAIN_W-1:0]        req_spot_gain = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_func_echo;
   logic [QUOT_W-1:0]        rsp_pixel_value;
   logic                     rsp_hit;
   logic [CNT_W-1:0]         rsp_hit_count;
   logic                     rsp_saturated;

   int                       mismatches;
   int                       pending_words;
   int                       idle_cycles = 0;
   int                       stall_run = 0;
   int                       stall_pick;
   int unsigned              cur_w = MAX_W;
   int unsigned              cur_h = MAX_H;
   // set per phase: no gaps, and no stalls once any stall run in progress ends
   bit                       quiet = 1'b0;

   spot_sample_accumulate_average_top #(
      .MAX_WIDTH  (MAX_W),
      .MAX_HEIGHT (MAX_H)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_sample_x    (req_sample_x),
      .req_sample_y    (req_sample_y),
      .req_spot_signal (req_spot_signal),
      .req_spot_gain   (req_spot_gain),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_func_echo   (rsp_func_echo),
      .rsp_pixel_value (rsp_pixel_value),
      .rsp_hit         (rsp_hit),
      .rsp_hit_count   (rsp_hit_count),
      .rsp_saturated   (rsp_saturated)
   );

   spot_sample_accumulate_average_checker #(
      .MAX_WIDTH  (MAX_W),
      .MAX_HEIGHT (MAX_H)
   ) checker_i (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_sample_x    (req_sample_x),
      .req_sample_y    (req_sample_y),
      .req_spot_signal (req_spot_signal),
      .req_spot_gain   (req_spot_gain),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_func_echo   (rsp_func_echo),
      .rsp_pixel_value (rsp_pixel_value),
      .rsp_hit         (rsp_hit),
      .rsp_hit_count   (rsp_hit_count),
      .rsp_saturated   (rsp_saturated),
      .mismatches      (mismatches),
      .pending_words   (pending_words)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Result side back-pressure: mostly short runs of stall or flow, now and
   // then a long stall. Runs are independent of rsp_valid so stalls land on
   // every phase of the block's work.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_run <= 0;
      end else if (stall_run != 0) begin
         stall_run <= stall_run - 1;
      end else if (quiet) begin
         rsp_stall <= 1'b0;
      end else begin
         stall_pick = $urandom_range(99);
         if (stall_pick < 60) begin
            rsp_stall <= 1'b0;
            stall_run <= $urandom_range(0, 4);
         end else if (stall_pick < 93) begin
            rsp_stall <= 1'b1;
            stall_run <= $urandom_range(0, 3);
         end else begin
            rsp_stall <= 1'b1;
            stall_run <= $urandom_range(10, 50);
         end
      end
   end

   // Watchdog: any cycle that moves a word on either side restarts the count.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("spot_sample_accumulate_average_top_tb NOT OK");
            $finish;
         end
      end
   end

   // Sender gap: mostly back to back or short, sometimes long; none in a quiet phase.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (quiet || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Position near the used image: a small cluster at the origin so pixels
   // collect repeated hits, the far edge just in and just out, and some
   // fully random words. The sub-pixel offset spans -8..7, so rounding in
   // both directions and small negatives are hit too.
   function automatic logic [POS_W-1:0] pick_pos(input int unsigned dim_reg);
      int unsigned span;
      int          pix;
      int          r;
      span = (dim_reg > MAX_W) ? MAX_W : dim_reg;
      r    = $urandom_range(99);
      if (r < 15) return POS_W'($urandom);
      if (r < 30) pix = int'(span) - 1 + int'($urandom_range(0, 2));
      else pix = $urandom_range(0, (span > 5) ? 5 : span);
      return POS_W'(pix * PIX_STEP + int'($urandom_range(0, 15)) - 8);
   endfunction

   // Present one request word after a random gap and hold it until taken.
   // Called right after the previous acceptance edge, so valid gets a single
   // assignment in that time step.
   task automatic send_word(input logic              f,
                            input logic [POS_W-1:0]  xs,
                            input logic [POS_W-1:0]  ys,
                            input logic [SIG_W-1:0]  sig,
                            input logic [GAIN_W-1:0] gain);
      int gap;
      gap = pick_gap();
      repeat (gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= f;
      req_sample_x    <= xs;
      req_sample_y    <= ys;
      req_spot_signal <= sig;
      req_spot_gain   <= gain;
      do @(posedge clock); while (req_stall);
   endtask

   // Both dimension registers, back to back; enable drops once at the end.
   task automatic write_dims(input int unsigned w, input int unsigned h);
      csr_wr_en   <= 1'b1;
      csr_index   <= ssaa_pkg::CSR_IMAGE_WIDTH;
      csr_wr_data <= DIM_W'(w);
      @(posedge clock);
      csr_index   <= ssaa_pkg::CSR_IMAGE_HEIGHT;
      csr_wr_data <= DIM_W'(h);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cur_w = w;
      cur_h = h;
   endtask

   // Let every outstanding word come back before touching the registers.
   // The first edge is taken before looking so the checker's count is current.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_words != 0);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      int unsigned phase_w [PHASES] = '{256, 1, 0, 511, 3, 256, 0, 2, 9};
      int unsigned phase_h [PHASES] = '{256, 1, 7, 511, 257, 1, 0, 2, 9};
      logic              f;
      logic [SIG_W-1:0]  sig;
      logic [GAIN_W-1:0] gain;
      int                r;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      // registers land even while the store sweep holds req_stall high
      write_dims(MAX_W, MAX_H);

      // ---- directed words, full 256 x 256 image ----
      // gain zero as one LSB, quotient clipped
      send_word(ssaa_pkg::FUNC_ACCUM, 0, 0, '1, 0);
      // zero quotient at the largest gain
      send_word(ssaa_pkg::FUNC_ACCUM, 0, 0, 0, '1);
      // average of a pixel hit twice
      send_word(ssaa_pkg::FUNC_READ, 0, 0, 0, 0);
      // pixel never hit
      send_word(ssaa_pkg::FUNC_READ, POS_W'(5 * PIX_STEP), POS_W'(5 * PIX_STEP), 0, 0);
      // 0.4375 rounds down, 0.5 rounds up; gain 1.0 passes the signal through
      send_word(ssaa_pkg::FUNC_ACCUM, 7, 8, 24'h123456, 16'h4000);
      // small negatives round to pixel zero and stay inside
      send_word(ssaa_pkg::FUNC_ACCUM, -16'sd7, -16'sd7, 24'h000100, 16'h4000);
      // -0.5 rounds to -1: off image on either axis
      send_word(ssaa_pkg::FUNC_ACCUM, -16'sd8, 0, 24'h000100, 16'h4000);
      send_word(ssaa_pkg::FUNC_ACCUM, 0, -16'sd8, 24'h000100, 16'h4000);
      // field extremes: most negative and most positive positions
      send_word(ssaa_pkg::FUNC_ACCUM, 16'h8000, 0, 24'h000100, 16'h4000);
      send_word(ssaa_pkg::FUNC_ACCUM, 16'h7FFF, 0, 24'h000100, 16'h4000);
      send_word(ssaa_pkg::FUNC_ACCUM, 0, 16'h7FFF, 24'h000100, 16'h4000);
      // last pixel of the image, largest signal over largest gain
      send_word(ssaa_pkg::FUNC_ACCUM, POS_W'(255 * PIX_STEP + 7),
                POS_W'(255 * PIX_STEP + 7), '1, '1);
      // one past the far edge
      send_word(ssaa_pkg::FUNC_ACCUM, POS_W'(255 * PIX_STEP + 8), 0, '1, '1);
      send_word(ssaa_pkg::FUNC_READ, POS_W'(255 * PIX_STEP + 7),
                POS_W'(255 * PIX_STEP + 7), 0, 0);
      // reads off the image
      send_word(ssaa_pkg::FUNC_READ, -16'sd8, 0, 0, 0);
      send_word(ssaa_pkg::FUNC_READ, 0, POS_W'(255 * PIX_STEP + 8), 0, 0);
      // 1.5 to 2, 1.4375 to 1; gain of one LSB around the clipping point
      send_word(ssaa_pkg::FUNC_ACCUM, 24, 23, 24'h000001, 16'h0001);
      send_word(ssaa_pkg::FUNC_ACCUM, 24, 23, 24'h0003FF, 16'h0001);
      send_word(ssaa_pkg::FUNC_ACCUM, 24, 23, 24'h000400, 16'h0001);
      send_word(ssaa_pkg::FUNC_READ, 24, 23, 0, 0);
      // signal and gain are don't-care on a read
      send_word(ssaa_pkg::FUNC_READ, 7, 8, '1, 0);

      // ---- random phases, each with its own image size ----
      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         if (ph == 6) write_dims($urandom_range(0, 511), $urandom_range(0, 511));
         else write_dims(phase_w[ph], phase_h[ph]);
         quiet = ($urandom_range(3) == 0);
         repeat (PHASE_WORDS) begin
            f = ($urandom_range(99) < 30) ? ssaa_pkg::FUNC_READ : ssaa_pkg::FUNC_ACCUM;
            r = $urandom_range(99);
            if (r < 10) sig = '1;
            else if (r < 20) sig = '0;
            else if (r < 50) sig = SIG_W'($urandom_range(0, 16'hFFFF));
            else sig = SIG_W'($urandom);
            r = $urandom_range(99);
            if (r < 10) gain = '0;
            else if (r < 20) gain = '1;
            else if (r < 40) gain = GAIN_W'($urandom_range(1, 16));
            else gain = GAIN_W'($urandom);
            send_word(f, pick_pos(cur_w), pick_pos(cur_h), sig, gain);
         end
      end
      quiet = 1'b0;

      req_valid <= 1'b0;
      do @(posedge clock); while (pending_words != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_words == 0) begin
         $display("spot_sample_accumulate_average_top_tb OK");
      end else begin
         $display("spot_sample_accumulate_average_top_tb NOT OK");
      end
      $finish;
   end

endmodule

@@ spot_sample_accumulate_average_top.f @@
rtl/core/ssaa_pkg.sv
rtl/core/ssaa_div.sv
rtl/core/ssaa_store.sv
rtl/core/spot_sample_accumulate_average_top.sv
verif/spot_sample_accumulate_average_checker.sv
verif/spot_sample_accumulate_average_top_tb.sv
